// ===== hw/rtl/ftxr_pkg.sv =====
// Package with constants and types shared by the lagged generator modules.
`timescale 1ns / 1ps
`default_nettype none
package ftxr_pkg;
  localparam int unsigned TABLE_DEPTH = 16384;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W = 31;
  localparam logic [IDX_W-1:0] TAP_A = IDX_W'(471);
  localparam logic [IDX_W-1:0] TAP_B = IDX_W'(1586);
  localparam logic [IDX_W-1:0] TAP_C = IDX_W'(6988);
  localparam logic [IDX_W-1:0] TAP_D = IDX_W'(9689);
  localparam logic [14:0] LEHMER_MULT = 15'd16807;
  localparam logic [WORD_W-1:0] LEHMER_PRIME = 31'h7FFFFFFF;

  localparam logic [1:0] KIND_SEED   = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_MOD    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seed_value;
    logic [30:0] modulus;
  } in_item_t;

  typedef struct packed {
    logic [30:0] value;
    logic        error;
  } out_item_t;

  // Request from the controller to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ftxr_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ftxr_in_if;
  logic              valid;
  logic              ready;
  ftxr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftxr_out_if;
  logic               valid;
  logic               ready;
  ftxr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ftxr_table_ram.sv =====
// Single-port lag table memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ftxr_table_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [ftxr_pkg::IDX_W-1:0]   addr,
  input  wire logic [ftxr_pkg::WORD_W-1:0]  wdata,
  output logic      [ftxr_pkg::WORD_W-1:0]  rdata
);
  logic [ftxr_pkg::WORD_W-1:0] mem [ftxr_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ftxr_lehmer.sv =====
// Lehmer step 16807 * x mod (2^31 - 1): registered product, combinational fold.
`timescale 1ns / 1ps
`default_nettype none
module ftxr_lehmer (
  input  wire logic                        clk,
  input  wire logic [ftxr_pkg::WORD_W-1:0] x,
  output logic      [ftxr_pkg::WORD_W-1:0] y
);
  logic [45:0] prod_r;
  logic [31:0] fold;
  logic [31:0] fold2;

  always_ff @(posedge clk) begin
    prod_r <= 46'(x) * 46'(ftxr_pkg::LEHMER_MULT);
  end

  // 2^31 == 1 mod p, so the high part folds onto the low part.
  assign fold  = {1'b0, prod_r[30:0]} + {17'd0, prod_r[45:31]};
  assign fold2 = {1'b0, fold[30:0]} + {31'd0, fold[31]};

  always_comb begin
    if (fold2[30:0] == ftxr_pkg::LEHMER_PRIME) begin
      y = '0;
    end else begin
      y = fold2[30:0];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ftxr_divider.sv =====
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ftxr_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ftxr_pkg::div_req_t req,
  output ftxr_pkg::div_rsp_t      rsp
);
  localparam int unsigned W = ftxr_pkg::WORD_W;
  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [W-1:0]  num_r;
  logic [W-1:0]  den_r;
  logic [W:0]    rem_r;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {rem_r[W-1:0], num_r[W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(W - 1);
        num_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem_r <= trial;
        end else begin
          rem_r <= shifted;
        end
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, rem: rem_r[W-1:0]};
endmodule
`default_nettype wire

// ===== hw/rtl/four_tap_xor_lagged_rng_unit.sv =====
// Top level of the four-tap XOR lagged random number generator.
// Usage:
//   Items enter on the in channel (valid/ready); one result leaves on the
//   out channel for every item. A transfer happens when valid and ready are
//   both high at a rising edge of clk.
//   A seed item walks the whole table through the Lehmer step, one entry
//   at a time. A draw reads the four tap entries from the single-port
//   table one per cycle, then writes the new word; the one memory port is
//   why the taps are read in turn. A modulo draw with a nonzero modulus
//   then passes through the bit-serial remainder unit. A negative seed or
//   an unused kind goes straight to the result, without the table.
//   One item is worked on at a time. The result sits in an output register;
//   the next item is accepted while it waits, but its result is held until
//   the receiver takes the previous one.
//   Reset (rst_n low, synchronous) clears the draw pointer and control
//   state; the table is undefined until a seed fills it. Draws before the
//   first seed give undefined words.
`timescale 1ns / 1ps
`default_nettype none
module four_tap_xor_lagged_rng_unit (
  input wire logic clk,
  input wire logic rst_n,
  ftxr_in_if.sink   in_ch,
  ftxr_out_if.source out_ch
);
  localparam int unsigned IW = ftxr_pkg::IDX_W;
  localparam int unsigned WW = ftxr_pkg::WORD_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SEED  = 8'b00000010,
    ST_READ  = 8'b00000100,
    ST_WRITE = 8'b00001000,
    ST_DIV   = 8'b00010000,
    ST_DWAIT = 8'b00100000,
    ST_DONE  = 8'b01000000,
    ST_SWAIT = 8'b10000000
  } state_t;

  state_t          state_r, state_nxt;
  ftxr_pkg::in_item_t item_r;
  logic [IW-1:0]   ptr_r;
  logic [IW-1:0]   addr_r;
  logic [2:0]      step_r;
  logic [WW-1:0]   acc_r;
  logic [WW-1:0]   x_r;
  logic [1:0]      sphase_r;
  logic            res_valid_r;
  ftxr_pkg::out_item_t res_r;
  ftxr_pkg::out_item_t pend_r;

  logic            ram_we;
  logic [IW-1:0]   ram_addr;
  logic [WW-1:0]   ram_wdata;
  logic [WW-1:0]   ram_rdata;
  logic [WW-1:0]   lehmer_y;
  logic [WW-1:0]   lehmer_x;
  ftxr_pkg::div_req_t div_req;
  ftxr_pkg::div_rsp_t div_rsp;
  logic [IW-1:0]   tap_off;
  logic            out_free;

  ftxr_table_ram u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );
  ftxr_lehmer u_lehmer (.clk(clk), .x(lehmer_x), .y(lehmer_y));
  ftxr_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign out_free    = !res_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = res_valid_r;
  assign out_ch.data  = res_r;

  always_comb begin
    case (step_r[1:0])
      2'd0:    tap_off = ftxr_pkg::TAP_A;
      2'd1:    tap_off = ftxr_pkg::TAP_B;
      2'd2:    tap_off = ftxr_pkg::TAP_C;
      default: tap_off = ftxr_pkg::TAP_D;
    endcase
  end

  // Seeding: the Lehmer unit input is the seed first, then the last entry.
  assign lehmer_x  = x_r;
  assign ram_we    = (state_r == ST_WRITE) ||
                     (state_r == ST_SEED && sphase_r == 2'd2);
  assign ram_wdata = (state_r == ST_SEED) ? lehmer_y : acc_r;
  assign ram_addr  = (state_r == ST_READ) ? ptr_r - tap_off : addr_r;

  assign div_req.start    = (state_r == ST_DIV);
  assign div_req.dividend = acc_r;
  assign div_req.divisor  = item_r.modulus;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.data.kind)
            ftxr_pkg::KIND_SEED: begin
              if (in_ch.data.seed_value[31]) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SEED;
              end
            end
            ftxr_pkg::KIND_RAW, ftxr_pkg::KIND_MOD: state_nxt = ST_READ;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SEED: begin
        if (sphase_r == 2'd2 && addr_r == '1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        if (step_r == 3'd4) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (item_r.kind == ftxr_pkg::KIND_MOD && item_r.modulus != '0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_SWAIT;
      ST_SWAIT: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // A new result replaces the old one in the same cycle it is taken.
      if (state_r == ST_SWAIT && out_free) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          item_r   <= in_ch.data;
          step_r   <= '0;
          sphase_r <= '0;
          addr_r   <= '0;
          acc_r    <= '0;
          x_r      <= in_ch.data.seed_value[WW-1:0];
          pend_r   <= '{value: '0,
                        error: (in_ch.data.kind == ftxr_pkg::KIND_SEED) &&
                               in_ch.data.seed_value[31]};
          if (in_ch.valid && (in_ch.data.kind == ftxr_pkg::KIND_RAW ||
                              in_ch.data.kind == ftxr_pkg::KIND_MOD)) begin
            ptr_r <= ptr_r + IW'(1);
          end
        end
        ST_SEED: begin
          if (sphase_r == 2'd2) begin
            sphase_r <= '0;
            x_r      <= lehmer_y;
            addr_r   <= addr_r + IW'(1);
          end else begin
            sphase_r <= sphase_r + 2'd1;
          end
        end
        ST_READ: begin
          step_r <= step_r + 3'd1;
          if (step_r != 3'd0) begin
            acc_r <= acc_r ^ ram_rdata;
          end
          addr_r <= ptr_r;
        end
        ST_WRITE: begin
          if (item_r.kind == ftxr_pkg::KIND_MOD && item_r.modulus == '0) begin
            pend_r <= '{value: '0, error: 1'b1};
          end else begin
            pend_r.value <= acc_r;
          end
        end
        ST_DWAIT: if (div_rsp.done) pend_r.value <= div_rsp.rem;
        ST_SWAIT: begin
          if (out_free) begin
            res_r <= pend_r;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
